// ===== hdl/quadratic_root_solver_unit_macros.svh =====
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define QRS_ASSERT_NEVER(lbl, clk, rst_n, a) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
    else $error("assertion failed");
`else
`define QRS_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define QRS_ASSERT_NEVER(lbl, clk, rst_n, a)
`endif
`endif

// ===== hdl/qrs_pkg.sv =====
// shared constants and types of the quadratic root solver
package qrs_pkg;
  localparam int CW      = 16;
  localparam int FB      = 16;
  localparam int ROOT_W  = 35;
  localparam int DISC_W  = 34;
  localparam int RAD_W   = 2 * (DISC_W + 2 * FB) / 2 + ((DISC_W + 2 * FB) % 2);
  localparam int SQ_N    = RAD_W / 2;
  localparam int REM_W   = SQ_N + 3;
  localparam int DEN_W   = CW + 1;
  localparam int DIV_W   = DEN_W + 1;
  localparam int DREM_W  = DIV_W + 1;
  localparam int NUM_W   = ROOT_W + 2;
  localparam int DV_N    = NUM_W;

  localparam logic [1:0] ST_TWO    = 2'd0;
  localparam logic [1:0] ST_DOUBLE = 2'd1;
  localparam logic [1:0] ST_AZERO  = 2'd2;
  localparam logic [1:0] ST_NEG    = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [CW-1:0]    b;
    logic [DEN_W-1:0] den;
    logic             aneg;
  } sq_side_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DIV_W-1:0] d;
    logic             aneg;
    logic             negp;
    logic             negm;
  } dv_side_t;
endpackage

// ===== hdl/qrs_sqrt_cell.sv =====
// one root bit of the pipelined square root
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [RAD_W-1:0] in_rad,
  input  logic [REM_W-1:0] in_rem,
  input  logic [SQ_N-1:0]  in_root,
  input  sq_side_t         in_side,
  output logic             out_vld,
  output logic [RAD_W-1:0] out_rad,
  output logic [REM_W-1:0] out_rem,
  output logic [SQ_N-1:0]  out_root,
  output sq_side_t         out_side
);
  logic             vld_r;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt, rem_sh, trial;
  logic [SQ_N-1:0]  root_r, root_nxt;
  sq_side_t         side_r;

  always_comb begin
    rem_sh  = {in_rem[REM_W-3:0], in_rad[RAD_W-1:RAD_W-2]};
    trial   = REM_W'({in_root, 2'b01});
    rad_nxt = {in_rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {in_root[SQ_N-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {in_root[SQ_N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;
endmodule

// ===== hdl/qrs_div_cell.sv =====
// one quotient bit of both pipelined dividers
module qrs_div_cell import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_np,
  input  logic [NUM_W-1:0]  in_nm,
  input  logic [DREM_W-1:0] in_rp,
  input  logic [DREM_W-1:0] in_rm,
  input  logic [NUM_W-1:0]  in_qp,
  input  logic [NUM_W-1:0]  in_qm,
  input  dv_side_t          in_side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  out_np,
  output logic [NUM_W-1:0]  out_nm,
  output logic [DREM_W-1:0] out_rp,
  output logic [DREM_W-1:0] out_rm,
  output logic [NUM_W-1:0]  out_qp,
  output logic [NUM_W-1:0]  out_qm,
  output dv_side_t          out_side
);
  logic              vld_r;
  logic [NUM_W-1:0]  np_r, nm_r, qp_r, qm_r, qp_nxt, qm_nxt;
  logic [DREM_W-1:0] rp_r, rm_r, rp_nxt, rm_nxt, shp, shm, dx;
  dv_side_t          side_r;

  always_comb begin
    dx  = {1'b0, in_side.d};
    shp = {in_rp[DREM_W-2:0], in_np[NUM_W-1]};
    shm = {in_rm[DREM_W-2:0], in_nm[NUM_W-1]};
    if (shp >= dx) begin
      rp_nxt = shp - dx;
      qp_nxt = {in_qp[NUM_W-2:0], 1'b1};
    end else begin
      rp_nxt = shp;
      qp_nxt = {in_qp[NUM_W-2:0], 1'b0};
    end
    if (shm >= dx) begin
      rm_nxt = shm - dx;
      qm_nxt = {in_qm[NUM_W-2:0], 1'b1};
    end else begin
      rm_nxt = shm;
      qm_nxt = {in_qm[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
    np_r   <= {in_np[NUM_W-2:0], 1'b0};
    nm_r   <= {in_nm[NUM_W-2:0], 1'b0};
    rp_r   <= rp_nxt;
    rm_r   <= rm_nxt;
    qp_r   <= qp_nxt;
    qm_r   <= qm_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_np   = np_r;
  assign out_nm   = nm_r;
  assign out_rp   = rp_r;
  assign out_rm   = rm_r;
  assign out_qp   = qp_r;
  assign out_qm   = qm_r;
  assign out_side = side_r;
endmodule

// ===== hdl/quadratic_root_solver_unit.sv =====
// top level of the quadratic root solver
// Fully pipelined: one coefficient word is taken every cycle (busy stays low) and
// its result leaves as a one-cycle out_valid strobe; the pipeline is two discriminant
// stages, 33 square root cells (one per root bit), one numerator stage, 37 divider
// cells (one per quotient bit) and one sign and saturation stage.
// The receiver cannot stall, so results must be captured when out_valid is high.
`include "quadratic_root_solver_unit_macros.svh"
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CW-1:0]     in_coef_a,
  input  logic signed [CW-1:0]     in_coef_b,
  input  logic signed [CW-1:0]     in_coef_c,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [ROOT_W-1:0] out_root_plus,
  output logic signed [ROOT_W-1:0] out_root_minus
);
  localparam logic [NUM_W-1:0] RMAX = NUM_W'(1) << (ROOT_W - 1);

  // stage one: magnitudes and products
  logic              v1_r, azero1_r, czero1_r, aneg1_r, cneg1_r;
  logic [DISC_W-1:0] bb1_r, ac1_r;
  logic [CW-1:0]     b1_r;
  logic [DEN_W-1:0]  am1_r;
  logic [DEN_W-1:0]  am, bm, cm;
  logic [2*DEN_W-1:0] bbw, acw;

  always_comb begin
    am = in_coef_a[CW-1] ? DEN_W'(-$signed({in_coef_a[CW-1], in_coef_a}))
                         : DEN_W'({1'b0, in_coef_a});
    bm = in_coef_b[CW-1] ? DEN_W'(-$signed({in_coef_b[CW-1], in_coef_b}))
                         : DEN_W'({1'b0, in_coef_b});
    cm = in_coef_c[CW-1] ? DEN_W'(-$signed({in_coef_c[CW-1], in_coef_c}))
                         : DEN_W'({1'b0, in_coef_c});
    bbw = bm * bm;
    acw = am * cm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    bb1_r    <= DISC_W'(bbw);
    ac1_r    <= DISC_W'(acw);
    am1_r    <= am;
    b1_r     <= in_coef_b;
    azero1_r <= (in_coef_a == '0);
    czero1_r <= (in_coef_c == '0);
    aneg1_r  <= in_coef_a[CW-1];
    cneg1_r  <= in_coef_c[CW-1];
  end

  // stage two: discriminant and class
  logic              v2_r;
  logic [DISC_W-1:0] disc2_r, disc_nxt, ac4;
  logic [1:0]        st_nxt;
  sq_side_t          side2_r;

  always_comb begin
    ac4 = {ac1_r[DISC_W-3:0], 2'b00};
    if ((aneg1_r != cneg1_r) && !czero1_r) disc_nxt = bb1_r + ac4;
    else disc_nxt = bb1_r - ac4;
    if (azero1_r) st_nxt = ST_AZERO;
    else if (!((aneg1_r != cneg1_r) && !czero1_r) && (bb1_r < ac4)) st_nxt = ST_NEG;
    else if (disc_nxt == '0) st_nxt = ST_DOUBLE;
    else st_nxt = ST_TWO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    disc2_r        <= disc_nxt;
    side2_r.status <= st_nxt;
    side2_r.b      <= b1_r;
    side2_r.den    <= DEN_W'({am1_r[DEN_W-2:0], 1'b0});
    side2_r.aneg   <= aneg1_r;
  end

  // square root chain
  logic             sv   [SQ_N+1];
  logic [RAD_W-1:0] srad [SQ_N+1];
  logic [REM_W-1:0] srem [SQ_N+1];
  logic [SQ_N-1:0]  sroot[SQ_N+1];
  sq_side_t         sside[SQ_N+1];

  assign sv[0]    = v2_r;
  assign srad[0]  = RAD_W'({disc2_r, {(2*FB){1'b0}}});
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side2_r;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_vld(sv[i]), .in_rad(srad[i]), .in_rem(srem[i]), .in_root(sroot[i]),
      .in_side(sside[i]),
      .out_vld(sv[i+1]), .out_rad(srad[i+1]), .out_rem(srem[i+1]),
      .out_root(sroot[i+1]), .out_side(sside[i+1])
    );
  end

  // numerator stage
  logic              v3_r;
  logic [NUM_W-1:0]  np3_r, nm3_r;
  dv_side_t          side3_r;
  logic [ROOT_W-1:0] nb, sx, nump, numm, magp, magm;
  sq_side_t          sq_o;

  always_comb begin
    sq_o = sside[SQ_N];
    nb   = ROOT_W'(0) - ROOT_W'({{(ROOT_W-CW){sq_o.b[CW-1]}}, sq_o.b} << FB);
    sx   = ROOT_W'(sroot[SQ_N]);
    nump = nb + sx;
    numm = nb - sx;
    magp = nump[ROOT_W-1] ? ROOT_W'(0) - nump : nump;
    magm = numm[ROOT_W-1] ? ROOT_W'(0) - numm : numm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= sv[SQ_N];
    np3_r          <= {1'b0, magp, 1'b0} + NUM_W'(sq_o.den);
    nm3_r          <= {1'b0, magm, 1'b0} + NUM_W'(sq_o.den);
    side3_r.status <= sq_o.status;
    side3_r.d      <= {sq_o.den, 1'b0};
    side3_r.aneg   <= sq_o.aneg;
    side3_r.negp   <= nump[ROOT_W-1];
    side3_r.negm   <= numm[ROOT_W-1];
  end

  // divider chain
  logic              dv   [DV_N+1];
  logic [NUM_W-1:0]  dnp  [DV_N+1];
  logic [NUM_W-1:0]  dnm  [DV_N+1];
  logic [DREM_W-1:0] drp  [DV_N+1];
  logic [DREM_W-1:0] drm  [DV_N+1];
  logic [NUM_W-1:0]  dqp  [DV_N+1];
  logic [NUM_W-1:0]  dqm  [DV_N+1];
  dv_side_t          dside[DV_N+1];

  assign dv[0]    = v3_r;
  assign dnp[0]   = np3_r;
  assign dnm[0]   = nm3_r;
  assign drp[0]   = '0;
  assign drm[0]   = '0;
  assign dqp[0]   = '0;
  assign dqm[0]   = '0;
  assign dside[0] = side3_r;

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_vld(dv[j]), .in_np(dnp[j]), .in_nm(dnm[j]), .in_rp(drp[j]), .in_rm(drm[j]),
      .in_qp(dqp[j]), .in_qm(dqm[j]), .in_side(dside[j]),
      .out_vld(dv[j+1]), .out_np(dnp[j+1]), .out_nm(dnm[j+1]),
      .out_rp(drp[j+1]), .out_rm(drm[j+1]), .out_qp(dqp[j+1]), .out_qm(dqm[j+1]),
      .out_side(dside[j+1])
    );
  end

  // sign, saturation and error masking
  logic              vo_r;
  logic [1:0]        sto_r;
  logic [ROOT_W-1:0] rp_r, rm_r, rp_nxt, rm_nxt;
  logic [NUM_W-1:0]  qp, qm, qps, qms, rpw, rmw;
  logic              ngp, ngm;
  dv_side_t          dv_o;

  always_comb begin
    dv_o = dside[DV_N];
    qp   = dqp[DV_N];
    qm   = dqm[DV_N];
    ngp  = (dv_o.negp != dv_o.aneg) && (qp != '0);
    ngm  = (dv_o.negm != dv_o.aneg) && (qm != '0);
    if (ngp) qps = (qp > RMAX) ? RMAX : qp;
    else qps = (qp > RMAX - NUM_W'(1)) ? RMAX - NUM_W'(1) : qp;
    if (ngm) qms = (qm > RMAX) ? RMAX : qm;
    else qms = (qm > RMAX - NUM_W'(1)) ? RMAX - NUM_W'(1) : qm;
    rpw = ngp ? NUM_W'(0) - qps : qps;
    rmw = ngm ? NUM_W'(0) - qms : qms;
    case (dv_o.status)
      ST_TWO: begin
        rp_nxt = rpw[ROOT_W-1:0];
        rm_nxt = rmw[ROOT_W-1:0];
      end
      ST_DOUBLE: begin
        rp_nxt = rpw[ROOT_W-1:0];
        rm_nxt = rpw[ROOT_W-1:0];
      end
      default: begin
        rp_nxt = '0;
        rm_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else vo_r <= dv[DV_N];
    sto_r <= dv_o.status;
    rp_r  <= rp_nxt;
    rm_r  <= rm_nxt;
  end

  assign busy           = 1'b0;
  assign out_valid      = vo_r;
  assign out_status     = sto_r;
  assign out_root_plus  = rp_r;
  assign out_root_minus = rm_r;

  `QRS_ASSERT_IMPLY(a_err_zero, clk, rst_n,
    out_valid && (out_status == ST_AZERO || out_status == ST_NEG),
    out_root_plus == '0 && out_root_minus == '0)
  `QRS_ASSERT_IMPLY(a_double_same, clk, rst_n,
    out_valid && out_status == ST_DOUBLE, out_root_plus == out_root_minus)
  `QRS_ASSERT_IMPLY(a_pipe_flow, clk, rst_n, v2_r, $past(v1_r))
endmodule

// ===== sim/tb_quadratic_root_solver_unit.sv =====
// testbench for the quadratic root solver: directed table then random words, checked by a predictor
module tb_quadratic_root_solver_unit;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 74;

  typedef struct packed {
    logic [1:0]        status;
    logic [ROOT_W-1:0] rplus;
    logic [ROOT_W-1:0] rminus;
  } roots_t;

  typedef struct {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    bit                   known;
    roots_t               res;
  } coef_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_coef_a = '0;
  logic signed [CW-1:0] in_coef_b = '0;
  logic signed [CW-1:0] in_coef_c = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [ROOT_W-1:0] out_root_plus;
  logic signed [ROOT_W-1:0] out_root_minus;

  roots_t expected_roots[$];
  int mismatches = 0;
  int sender_idle_pct = 0;

  quadratic_root_solver_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_status(out_status),
    .out_root_plus(out_root_plus), .out_root_minus(out_root_minus)
  );

  always #5 clk = ~clk;

  function automatic logic [ROOT_W-1:0] rounded_quotient(logic signed [127:0] num,
                                                         logic signed [127:0] den);
    logic [127:0] nm, dm, q;
    logic signed [127:0] sq;
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    q = (2 * nm + dm) / (2 * dm);
    sq = ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    if (sq > (128'sd1 <<< 34) - 1) sq = (128'sd1 <<< 34) - 1;
    if (sq < -(128'sd1 <<< 34)) sq = -(128'sd1 <<< 34);
    return sq[ROOT_W-1:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                         logic signed [CW-1:0] c);
    roots_t r;
    logic signed [127:0] disc, nb, den;
    logic [127:0] scaled, s, cand;
    r = '0;
    if (a == 0) begin
      r.status = ST_AZERO;
      return r;
    end
    disc = 128'(b) * 128'(b) - 4 * 128'(a) * 128'(c);
    if (disc < 0) begin
      r.status = ST_NEG;
      return r;
    end
    scaled = disc << (2 * FB);
    s = '0;
    for (int k = 57; k >= 0; k--) begin
      cand = s | (128'd1 << k);
      if (cand * cand <= scaled) s = cand;
    end
    nb = -(128'(b) <<< FB);
    den = 2 * 128'(a);
    r.status = disc == 0 ? ST_DOUBLE : ST_TWO;
    r.rplus = rounded_quotient(nb + $signed(s), den);
    r.rminus = disc == 0 ? r.rplus : rounded_quotient(nb - $signed(s), den);
    return r;
  endfunction

  task automatic send_word(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                           logic signed [CW-1:0] c, bit known, roots_t res);
    roots_t pred;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    pred = solve_roots(a, b, c);
    if (known && pred !== res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %0d %0d %0d: typed %h predicted %h", a, b, c, res, pred);
    end
    start <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_roots.push_back(pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_status);
      end else begin
        roots_t e;
        e = expected_roots.pop_front();
        if (out_status !== e.status || out_root_plus !== e.rplus ||
            out_root_minus !== e.rminus) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected %0d %h %h got %0d %h %h", e.status, e.rplus, e.rminus,
                     out_status, out_root_plus, out_root_minus);
        end
      end
    end
  end

  function automatic logic signed [CW-1:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return CW'($signed($urandom_range(8)) - 4);
      3: return CW'($signed($urandom_range(200)) - 100);
      default: return CW'($urandom);
    endcase
  endfunction

  coef_row_t stim_table[] = '{
    '{16'sd0, 16'sd5, 16'sd3, 1'b1, '{ST_AZERO, 35'd0, 35'd0}},
    '{16'sd0, 16'sh8000, 16'sh7fff, 1'b1, '{ST_AZERO, 35'd0, 35'd0}},
    '{16'sd1, 16'sd0, 16'sd1, 1'b1, '{ST_NEG, 35'd0, 35'd0}},
    '{16'sh7fff, 16'sd0, 16'sh7fff, 1'b1, '{ST_NEG, 35'd0, 35'd0}},
    '{16'sd1, 16'sd0, 16'sd0, 1'b1, '{ST_DOUBLE, 35'd0, 35'd0}},
    '{16'sd1, -16'sd2, 16'sd1, 1'b1, '{ST_DOUBLE, 35'h10000, 35'h10000}},
    '{16'sd1, -16'sd3, 16'sd2, 1'b1, '{ST_TWO, 35'h20000, 35'h10000}},
    '{16'sd1, 16'sd0, -16'sd1, 1'b1, '{ST_TWO, 35'h10000, -35'sh10000}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sd1, 16'sh8000, 16'sd0, 1'b0, '0},
    '{16'sd1, 16'sh7fff, 16'sh8000, 1'b0, '0},
    '{-16'sd1, 16'sd1, 16'sd1, 1'b0, '0},
    '{16'sd3, 16'sd1, 16'sd0, 1'b0, '0},
    '{16'sd2, 16'sd3, -16'sd5, 1'b0, '0},
    '{16'sh7fff, 16'sd1, -16'sd1, 1'b0, '0},
    '{-16'sd1, 16'sh7fff, 16'sh7fff, 1'b0, '0},
    '{16'shffff, 16'shffff, 16'shffff, 1'b0, '0},
    '{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '0}
  };

  initial begin
    logic signed [CW-1:0] a, b, c;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (stim_table[i])
      send_word(stim_table[i].a, stim_table[i].b, stim_table[i].c,
                stim_table[i].known, stim_table[i].res);
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = phase == 0 ? 15 : (phase == 1 ? 48 : 0);
      for (int n = 0; n < 360; n++) begin
        a = pick_coef();
        b = pick_coef();
        c = pick_coef();
        if ($urandom_range(3) == 0) begin
          c = CW'($signed($urandom_range(60)) - 30);
          b = CW'(2 * c);
          a = c;
        end
        send_word(a, b, c, 1'b0, '0);
      end
      drain_results();
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && expected_roots.size() == 0)
      $display("tb_quadratic_root_solver_unit: clean");
    else
      $display("tb_quadratic_root_solver_unit: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_quadratic_root_solver_unit: errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver_unit.sv
sim/tb_quadratic_root_solver_unit.sv
